FILE: hdl/aas_pkg.sv
// ----------------------------------------------------------------------------
// aas_pkg
// Shared widths, field offsets and item codes of the attractor acceleration
// block.
// ----------------------------------------------------------------------------
package aas_pkg;

  // Attractor store
  localparam int unsigned MAX_ATTR  = 8;
  localparam int unsigned IDX_W     = (MAX_ATTR > 1) ? $clog2(MAX_ATTR) : 1;

  // Fixed point
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned Q_W       = 32;
  localparam int unsigned PROD_W    = 2 * Q_W;
  localparam int unsigned TERM_W    = PROD_W - FRAC_BITS;
  localparam int unsigned SUM_W     = TERM_W + 2;
  localparam int unsigned NUM_W     = Q_W + 2 * FRAC_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W);

  // Field widths
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned AXES      = 3;

  // Input tdata layout: slot, x, y, z, strength, acc_x, acc_y, acc_z
  localparam int unsigned SLOT_LSB  = 0;
  localparam int unsigned X_LSB     = SLOT_LSB + SLOT_W;
  localparam int unsigned Y_LSB     = X_LSB + Q_W;
  localparam int unsigned Z_LSB     = Y_LSB + Q_W;
  localparam int unsigned STR_LSB   = Z_LSB + Q_W;
  localparam int unsigned AX_LSB    = STR_LSB + Q_W;
  localparam int unsigned AY_LSB    = AX_LSB + Q_W;
  localparam int unsigned AZ_LSB    = AY_LSB + Q_W;
  localparam int unsigned S_FIELD_W = AZ_LSB + Q_W;
  localparam int unsigned S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;

  // Output tdata layout: new_acc_x, new_acc_y, new_acc_z
  localparam int unsigned M_TDATA_W = AXES * Q_W;

  // Item kind carried in s_axis_tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef logic signed [Q_W-1:0] q_t;

endpackage

FILE: hdl/attractor_acceleration_sum_top.sv
// A load item writes its slot of the attractor store when the slot is in range and leaves the
//   block idle; an update item runs the steps below for each active attractor, then loads the output register.
// Active attractors: the configured count clamped to the slot capacity. Per attractor: offset,
//   square, check, divide, scale, multiply/accumulate; a coincident one stops after the check.
// Throughput: one item in flight; a finished result waits in the output register
//   while the next item is taken. Reset: async, active low; clears control and count.
// ----------------------------------------------------------------------------
// attractor_acceleration_sum_top
// Point-attractor acceleration for a particle stream, Q16.16 with saturation,
// computed by a sequencer around one multiplier and one divider step.
// ----------------------------------------------------------------------------
module attractor_acceleration_sum_top
  import aas_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration: attractor_count
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CNT_W-1:0]     cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // slot, x, y, z, strength, acc_x, acc_y, acc_z
  input  logic                 s_axis_tuser,  // op
  input  logic                 s_axis_tlast,  // last_particle
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // new_acc_x, new_acc_y, new_acc_z
  output logic                 m_axis_tuser,  // zero_distance
  output logic                 m_axis_tlast   // frame_end
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_OFF   = 4'd1;
  localparam logic [3:0] ST_SQ    = 4'd2;
  localparam logic [3:0] ST_SQA   = 4'd3;
  localparam logic [3:0] ST_DCHK  = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_SCALE = 4'd6;
  localparam logic [3:0] ST_TMUL  = 4'd7;
  localparam logic [3:0] ST_TADD  = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  localparam logic [1:0] AXIS_LAST = 2'(AXES - 1);

  // control
  logic [3:0]           state_q, state_d;
  logic [1:0]           axis_q, axis_d;
  logic [IDX_W:0]       idx_q, idx_d;
  logic [DIV_CNT_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]     count_q;
  logic                 out_valid_q, out_valid_d;

  // payload
  q_t                   pos_q [AXES];
  q_t                   acc_q [AXES];
  logic [Q_W-1:0]       off_mag_q [AXES];
  logic                 off_neg_q [AXES];
  logic                 zero_q, last_q;
  logic [PROD_W-1:0]    prod_q, d2_q, rem_q;
  logic [NUM_W-1:0]     num_q;
  logic [Q_W-1:0]       quo_q, s_mag_q;
  logic                 quo_sat_q, s_neg_q;
  q_t                   out_acc_q [AXES];
  logic                 out_zero_q, out_last_q;

  // attractor store
  q_t                   attr_pos_q [MAX_ATTR][AXES];
  q_t                   attr_str_q [MAX_ATTR];

  logic                 in_xfer, out_xfer, out_load;
  logic [IDX_W:0]       count_eff;
  logic [IDX_W-1:0]     rd_idx, wr_idx;

  logic signed [Q_W:0]  diff;
  q_t                   off_sat;
  logic [Q_W-1:0]       str_mag;
  logic [Q_W-1:0]       mul_a, mul_b;
  logic [PROD_W:0]      rem_shift;
  logic                 rem_ge;
  logic [TERM_W-1:0]    term;
  logic signed [SUM_W-1:0] acc_ext, term_ext, sum;
  q_t                   acc_new;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign out_xfer      = out_valid_q & m_axis_tready;
  assign out_load      = (state_q == ST_DONE) & (~out_valid_q | m_axis_tready);

  assign count_eff = (32'(count_q) > MAX_ATTR) ? (IDX_W + 1)'(MAX_ATTR)
                                               : (IDX_W + 1)'(count_q);
  assign rd_idx    = idx_q[IDX_W-1:0];
  assign wr_idx    = IDX_W'(s_axis_tdata[SLOT_LSB +: SLOT_W]);

  // Offset of the current axis, saturated to 32 bits
  always_comb begin
    diff = {attr_pos_q[rd_idx][axis_q][Q_W-1], attr_pos_q[rd_idx][axis_q]}
         - {pos_q[axis_q][Q_W-1], pos_q[axis_q]};
    if (diff[Q_W] != diff[Q_W-1]) begin
      off_sat = diff[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end else begin
      off_sat = diff[Q_W-1:0];
    end
  end

  assign str_mag = attr_str_q[rd_idx][Q_W-1] ? Q_W'(-attr_str_q[rd_idx])
                                             : Q_W'(attr_str_q[rd_idx]);

  // Shared multiplier operands
  always_comb begin
    mul_a = off_mag_q[axis_q];
    mul_b = (state_q == ST_TMUL) ? s_mag_q : off_mag_q[axis_q];
  end

  // Restoring divider step
  assign rem_shift = {rem_q, num_q[NUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, d2_q});

  // Accumulate one term with saturation
  always_comb begin
    term     = prod_q[PROD_W-1:FRAC_BITS];
    acc_ext  = SUM_W'(acc_q[axis_q]);
    term_ext = $signed({2'b00, term});
    sum      = (off_neg_q[axis_q] ^ s_neg_q) ? (acc_ext - term_ext)
                                             : (acc_ext + term_ext);
    if ((&sum[SUM_W-1:Q_W-1]) || ~(|sum[SUM_W-1:Q_W-1])) begin
      acc_new = sum[Q_W-1:0];
    end else begin
      acc_new = sum[SUM_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    idx_d       = idx_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && s_axis_tuser == OP_UPDATE) begin
          idx_d   = '0;
          axis_d  = '0;
          state_d = (count_eff == '0) ? ST_DONE : ST_OFF;
        end
      end
      ST_OFF: begin
        if (axis_q == AXIS_LAST) begin
          axis_d  = '0;
          state_d = ST_SQ;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      ST_SQ: begin
        state_d = ST_SQA;
      end
      ST_SQA: begin
        if (axis_q == AXIS_LAST) begin
          axis_d  = '0;
          state_d = ST_DCHK;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_SQ;
        end
      end
      ST_DCHK: begin
        if (d2_q == '0) begin
          // coincident attractor: skip it
          idx_d   = idx_q + 1'b1;
          state_d = (idx_q + 1'b1 == count_eff) ? ST_DONE : ST_OFF;
        end else begin
          step_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        step_d = step_q + 1'b1;
        if (step_q == DIV_CNT_W'(NUM_W - 1)) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_d = ST_TMUL;
      end
      ST_TMUL: begin
        state_d = ST_TADD;
      end
      ST_TADD: begin
        if (axis_q == AXIS_LAST) begin
          axis_d  = '0;
          idx_d   = idx_q + 1'b1;
          state_d = (idx_q + 1'b1 == count_eff) ? ST_DONE : ST_OFF;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_TMUL;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  // Attractor store: written by load items
  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tuser == OP_LOAD &&
        32'(s_axis_tdata[SLOT_LSB +: SLOT_W]) < MAX_ATTR) begin
      attr_pos_q[wr_idx][0] <= s_axis_tdata[X_LSB +: Q_W];
      attr_pos_q[wr_idx][1] <= s_axis_tdata[Y_LSB +: Q_W];
      attr_pos_q[wr_idx][2] <= s_axis_tdata[Z_LSB +: Q_W];
      attr_str_q[wr_idx]    <= s_axis_tdata[STR_LSB +: Q_W];
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          pos_q[0] <= s_axis_tdata[X_LSB +: Q_W];
          pos_q[1] <= s_axis_tdata[Y_LSB +: Q_W];
          pos_q[2] <= s_axis_tdata[Z_LSB +: Q_W];
          acc_q[0] <= s_axis_tdata[AX_LSB +: Q_W];
          acc_q[1] <= s_axis_tdata[AY_LSB +: Q_W];
          acc_q[2] <= s_axis_tdata[AZ_LSB +: Q_W];
          last_q   <= s_axis_tlast;
          zero_q   <= 1'b0;
        end
      end
      ST_OFF: begin
        off_mag_q[axis_q] <= off_sat[Q_W-1] ? Q_W'(-off_sat) : Q_W'(off_sat);
        off_neg_q[axis_q] <= off_sat[Q_W-1];
        if (axis_q == '0) begin
          d2_q <= '0;
        end
      end
      ST_SQA: begin
        d2_q <= d2_q + prod_q;
      end
      ST_DCHK: begin
        if (d2_q == '0) begin
          zero_q <= 1'b1;
        end
        num_q     <= NUM_W'(str_mag) << (2 * FRAC_BITS);
        rem_q     <= '0;
        quo_q     <= '0;
        quo_sat_q <= 1'b0;
        s_neg_q   <= attr_str_q[rd_idx][Q_W-1];
      end
      ST_DIV: begin
        num_q     <= num_q << 1;
        rem_q     <= rem_ge ? PROD_W'(rem_shift - {1'b0, d2_q}) : PROD_W'(rem_shift);
        quo_q     <= {quo_q[Q_W-2:0], rem_ge};
        quo_sat_q <= quo_sat_q | quo_q[Q_W-1];
      end
      ST_SCALE: begin
        // quotient at or above 2^31 clips to the signed range
        if (quo_sat_q || quo_q[Q_W-1]) begin
          s_mag_q <= s_neg_q ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end else begin
          s_mag_q <= quo_q;
        end
      end
      ST_TADD: begin
        acc_q[axis_q] <= acc_new;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_acc_q[0] <= acc_q[0];
      out_acc_q[1] <= acc_q[1];
      out_acc_q[2] <= acc_q[2];
      out_zero_q   <= zero_q;
      out_last_q   <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_acc_q[2], out_acc_q[1], out_acc_q[0]};
  assign m_axis_tuser  = out_zero_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: hdl/aas_checker.sv
// ----------------------------------------------------------------------------
// aas_checker
// Port-level checks of the attractor acceleration block, bound to the top.
// ----------------------------------------------------------------------------
module aas_checker
  import aas_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser,
  input logic                 m_axis_tlast
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // An update transfer occupies the block
  a_update_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_UPDATE |=> !s_axis_tready)
    else $error("ready after an update transfer");

  // A load transfer never stalls the input
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD |=> s_axis_tready)
    else $error("load transfer blocked the input");

  // A new result only comes out of a busy phase
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a preceding update");

endmodule

bind attractor_acceleration_sum_top aas_checker u_aas_checker (.*);
